/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file adsd_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ADSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adsd assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ADSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adsd assertion failed");

`endif

/* rtl/adsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsd_pkg
// Types, constants and codes for the ADC stream decompressor.
// ----------------------------------------------------------------------------
package adsd_pkg;

  localparam int HIST_DEPTH  = 65536;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int FILL_W      = $clog2(HIST_DEPTH + 1);
  localparam int DIST_W      = 17;
  localparam int CALC_W      = ((FILL_W > DIST_W) ? FILL_W : DIST_W) + 1;
  localparam int LEN_W       = 7;
  localparam int RUN_W       = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [DIST_W-1:0] LONG_MAX_DIST  = DIST_W'(32'h10000);
  localparam logic [DIST_W-1:0] SHORT_MAX_DIST = DIST_W'(32'h400);

  localparam logic [7:0] OP_LITERAL_BIT = 8'h80;
  localparam logic [7:0] OP_LONG_BIT    = 8'h40;
  localparam logic [7:0] LIT_LEN_MASK   = 8'h7F;
  localparam logic [7:0] LONG_LEN_MASK  = 8'h3F;
  localparam logic [7:0] SHORT_LEN_MASK = 8'h3C;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_END = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LONG_HI = 3'd1,
    PH_LONG_LO = 3'd2,
    PH_SHORT   = 3'd3,
    PH_LITERAL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_EMPTY = 2'd0,
    OP_LIT   = 2'd1,
    OP_COPY  = 2'd2
  } op_kind_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_READ  = 2'd1,
    B_WRITE = 2'd2
  } back_state_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [1:0]        status;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] distance;
  } op_t;

endpackage

/* rtl/adsd_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsd channel interfaces
// Valid/ready channels for compressed input words and decoded result words.
// ----------------------------------------------------------------------------
interface adsd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;

  modport source (output valid, cmd, in_byte, input ready);
  modport sink   (input valid, cmd, in_byte, output ready);
endinterface

interface adsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic [1:0] status;
  logic       last;

  modport source (output valid, first_byte, second_byte, byte_count, status, last,
                  input ready);
  modport sink   (input valid, first_byte, second_byte, byte_count, status, last,
                  output ready);
endinterface

/* rtl/adsd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsd_front
// Parses compressed words, tracks history fill and issues back-end ops.
// ----------------------------------------------------------------------------
module adsd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  input  logic [7:0]     in_byte,
  input  logic           q_full,
  output logic           q_push,
  output adsd_pkg::op_t  q_op
);

  adsd_pkg::phase_t                 phase_r, phase_nxt;
  logic [adsd_pkg::RUN_W-1:0]       run_r, run_nxt;
  logic [adsd_pkg::DIST_W-1:0]      dist_r, dist_nxt;
  logic [adsd_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic                             err_r, err_nxt;

  logic                             accept;
  logic [adsd_pkg::DIST_W-1:0]      dist_sum;
  logic [adsd_pkg::CALC_W-1:0]      dist_ext;
  logic [adsd_pkg::CALC_W-1:0]      fill_ext;
  logic                             dist_bad;
  logic [adsd_pkg::FILL_W:0]        fill_add;
  logic [adsd_pkg::FILL_W:0]        fill_sum;
  logic [adsd_pkg::RUN_W-1:0]       run_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  assign dist_sum = dist_r + adsd_pkg::DIST_W'(in_byte) + adsd_pkg::DIST_W'(1);
  assign dist_ext = adsd_pkg::CALC_W'(dist_sum);
  assign fill_ext = adsd_pkg::CALC_W'(fill_r);
  assign dist_bad = (dist_sum > adsd_pkg::LONG_MAX_DIST)
                 || ((phase_r == adsd_pkg::PH_SHORT) && (dist_sum > adsd_pkg::SHORT_MAX_DIST))
                 || (dist_ext > fill_ext)
                 || (dist_sum == '0);
  assign run_dec  = (run_r != '0) ? run_r - 1'b1 : run_r;

  always_comb begin
    fill_add = '0;
    if (phase_r == adsd_pkg::PH_LITERAL) begin
      fill_add = (adsd_pkg::FILL_W+1)'(1);
    end else begin
      fill_add = (adsd_pkg::FILL_W+1)'(run_r);
    end
    fill_sum = {1'b0, fill_r} + fill_add;
  end

  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    dist_nxt  = dist_r;
    fill_nxt  = fill_r;
    err_nxt   = err_r;
    q_op      = '{kind: adsd_pkg::OP_EMPTY, status: adsd_pkg::ST_OK, data: in_byte,
                  len: run_r[adsd_pkg::LEN_W-1:0], distance: dist_sum};
    if (err_r) begin
      q_op.status = adsd_pkg::ST_ERR;
    end else if (in_cmd == adsd_pkg::CMD_END) begin
      q_op.status = (phase_r == adsd_pkg::PH_OPCODE) ? adsd_pkg::ST_END : adsd_pkg::ST_ERR;
    end else begin
      unique case (phase_r)
        adsd_pkg::PH_LONG_HI: begin
          dist_nxt  = adsd_pkg::DIST_W'({in_byte, 8'h00});
          phase_nxt = adsd_pkg::PH_LONG_LO;
        end
        adsd_pkg::PH_LONG_LO, adsd_pkg::PH_SHORT: begin
          dist_nxt  = dist_sum;
          phase_nxt = adsd_pkg::PH_OPCODE;
          run_nxt   = '0;
          if (dist_bad) begin
            err_nxt     = 1'b1;
            q_op.status = adsd_pkg::ST_ERR;
          end else begin
            q_op.kind = adsd_pkg::OP_COPY;
            fill_nxt  = (fill_sum > (adsd_pkg::FILL_W+1)'(adsd_pkg::HIST_DEPTH))
                      ? adsd_pkg::FILL_W'(adsd_pkg::HIST_DEPTH)
                      : fill_sum[adsd_pkg::FILL_W-1:0];
          end
        end
        adsd_pkg::PH_LITERAL: begin
          q_op.kind = adsd_pkg::OP_LIT;
          fill_nxt  = (fill_sum > (adsd_pkg::FILL_W+1)'(adsd_pkg::HIST_DEPTH))
                    ? adsd_pkg::FILL_W'(adsd_pkg::HIST_DEPTH)
                    : fill_sum[adsd_pkg::FILL_W-1:0];
          run_nxt   = run_dec;
          if (run_dec == '0) begin
            phase_nxt = adsd_pkg::PH_OPCODE;
          end
        end
        default: begin
          // opcode word
          if ((in_byte & adsd_pkg::OP_LITERAL_BIT) != '0) begin
            phase_nxt = adsd_pkg::PH_LITERAL;
            dist_nxt  = '0;
            run_nxt   = (in_byte & adsd_pkg::LIT_LEN_MASK) + 8'd1;
          end else if ((in_byte & adsd_pkg::OP_LONG_BIT) != '0) begin
            phase_nxt = adsd_pkg::PH_LONG_HI;
            dist_nxt  = '0;
            run_nxt   = (in_byte & adsd_pkg::LONG_LEN_MASK) + 8'd4;
          end else begin
            phase_nxt = adsd_pkg::PH_SHORT;
            dist_nxt  = adsd_pkg::DIST_W'({in_byte[1:0], 8'h00});
            run_nxt   = ((in_byte & adsd_pkg::SHORT_LEN_MASK) >> 2) + 8'd3;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= adsd_pkg::PH_OPCODE;
      run_r   <= '0;
      dist_r  <= '0;
      fill_r  <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      dist_r  <= dist_nxt;
      fill_r  <= fill_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* rtl/adsd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsd_queue
// Short op queue between the parser and the history engine.
// ----------------------------------------------------------------------------
module adsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  adsd_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output adsd_pkg::op_t  head_op
);

  adsd_pkg::op_t                 slot_r [adsd_pkg::QUEUE_DEPTH];
  logic [adsd_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [adsd_pkg::QUEUE_AW:0]   count_r, count_nxt;

  assign full       = (count_r == (adsd_pkg::QUEUE_AW+1)'(adsd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == adsd_pkg::QUEUE_AW'(adsd_pkg::QUEUE_DEPTH-1))
                  ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == adsd_pkg::QUEUE_AW'(adsd_pkg::QUEUE_DEPTH-1))
                  ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/adsd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsd_back
// History ring, copy engine and result word packer.
// ----------------------------------------------------------------------------
module adsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  adsd_pkg::op_t  q_op,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_first_byte,
  output logic [7:0]     out_second_byte,
  output logic [1:0]     out_byte_count,
  output logic [1:0]     out_status,
  output logic           out_last
);

  logic [7:0]                    hist_mem [adsd_pkg::HIST_DEPTH];
  logic [7:0]                    rd_data_r;

  adsd_pkg::back_state_t         state_r, state_nxt;
  logic [adsd_pkg::HIST_AW-1:0]  wp_r;
  logic [adsd_pkg::LEN_W-1:0]    len_r;
  logic [adsd_pkg::DIST_W-1:0]   dist_r;
  logic                          pend_r;
  logic [7:0]                    pend_byte_r;

  logic                          out_valid_r;
  logic [7:0]                    first_r, second_r;
  logic [1:0]                    count_r, status_r;
  logic                          last_r;

  logic                          out_free;
  logic                          copy_final;
  logic                          advance;
  logic                          wr_en;
  logic [7:0]                    wr_data;
  logic                          rd_en;
  logic [adsd_pkg::CALC_W-1:0]   wp_ext, d_ext, rd_full;
  logic [adsd_pkg::HIST_AW-1:0]  rd_addr;
  logic                          emit;
  logic [7:0]                    emit_first, emit_second;
  logic [1:0]                    emit_count, emit_status;

  assign out_free   = !out_valid_r || out_ready;
  assign copy_final = (len_r == adsd_pkg::LEN_W'(1));
  // a held first byte needs no output slot, a pair or the final byte does
  assign advance    = (!pend_r && !copy_final) || out_free;

  assign wp_ext  = adsd_pkg::CALC_W'(wp_r);
  assign d_ext   = adsd_pkg::CALC_W'(dist_r);
  assign rd_full = (wp_ext >= d_ext) ? wp_ext - d_ext
                                     : wp_ext + adsd_pkg::CALC_W'(adsd_pkg::HIST_DEPTH) - d_ext;
  assign rd_addr = rd_full[adsd_pkg::HIST_AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      adsd_pkg::B_IDLE: begin
        if (q_valid && (q_op.kind == adsd_pkg::OP_COPY)) begin
          state_nxt = adsd_pkg::B_READ;
        end
      end
      adsd_pkg::B_READ: begin
        state_nxt = adsd_pkg::B_WRITE;
      end
      adsd_pkg::B_WRITE: begin
        if (advance) begin
          state_nxt = copy_final ? adsd_pkg::B_IDLE : adsd_pkg::B_READ;
        end
      end
      default: begin
        state_nxt = adsd_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = q_op.data;
    rd_en       = 1'b0;
    emit        = 1'b0;
    emit_first  = '0;
    emit_second = '0;
    emit_count  = 2'd0;
    emit_status = adsd_pkg::ST_OK;
    unique case (state_r)
      adsd_pkg::B_IDLE: begin
        if (q_valid) begin
          if (q_op.kind == adsd_pkg::OP_COPY) begin
            q_pop = 1'b1;
          end else if (out_free) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            if (q_op.kind == adsd_pkg::OP_LIT) begin
              wr_en      = 1'b1;
              emit_first = q_op.data;
              emit_count = 2'd1;
            end else begin
              emit_status = q_op.status;
            end
          end
        end
      end
      adsd_pkg::B_READ: begin
        rd_en = 1'b1;
      end
      adsd_pkg::B_WRITE: begin
        if (advance) begin
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          if (pend_r) begin
            emit        = 1'b1;
            emit_first  = pend_byte_r;
            emit_second = rd_data_r;
            emit_count  = 2'd2;
          end else if (copy_final) begin
            emit       = 1'b1;
            emit_first = rd_data_r;
            emit_count = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      first_r  <= emit_first;
      second_r <= emit_second;
      count_r  <= emit_count;
      status_r <= emit_status;
      last_r   <= (state_r == adsd_pkg::B_IDLE) || copy_final;
    end
    if (state_r == adsd_pkg::B_WRITE && advance && !emit) begin
      pend_byte_r <= rd_data_r;
    end
    if (state_r == adsd_pkg::B_IDLE && q_pop) begin
      dist_r <= q_op.distance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adsd_pkg::B_IDLE;
      wp_r        <= '0;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        wp_r <= (wp_r == adsd_pkg::HIST_AW'(adsd_pkg::HIST_DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (state_r == adsd_pkg::B_IDLE && q_pop && q_op.kind == adsd_pkg::OP_COPY) begin
        len_r <= q_op.len;
      end else if (state_r == adsd_pkg::B_WRITE && advance) begin
        len_r <= len_r - 1'b1;
      end
      if (state_r == adsd_pkg::B_WRITE && advance) begin
        pend_r <= !emit;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_byte  = first_r;
  assign out_second_byte = second_r;
  assign out_byte_count  = count_r;
  assign out_status      = status_r;
  assign out_last        = last_r;

endmodule

/* rtl/adc_stream_decompressor.sv */
`timescale 1ns / 1ps
// Result path: an accepted word is registered in the op queue, then in the result word registers.
// Throughput: one input word per cycle for opcodes, offsets and literals, held while the queue
// is full; a copy moves its bytes one at a time through the history engine, each read and then
// written back (B_READ, then B_WRITE) over the single history read port.
// Reset: synchronous, active low; clears parser, queue and engine control.
// History content is not cleared; copies never read beyond the filled part.
// ----------------------------------------------------------------------------
// adc_stream_decompressor
// ADC stream decoder: parser front end, op queue, history copy back end.
// ----------------------------------------------------------------------------
module adc_stream_decompressor (
  input  logic               clk,
  input  logic               rst_n,
  adsd_in_if.sink            in_ch,
  adsd_out_if.source         out_ch
);

  logic           q_full;
  logic           q_push;
  adsd_pkg::op_t  q_push_op;
  logic           q_pop;
  logic           q_head_valid;
  adsd_pkg::op_t  q_head_op;

  adsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cmd   (in_ch.cmd),
    .in_byte  (in_ch.in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_push_op)
  );

  adsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  adsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_head_valid),
    .q_op            (q_head_op),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_first_byte  (out_ch.first_byte),
    .out_second_byte (out_ch.second_byte),
    .out_byte_count  (out_ch.byte_count),
    .out_status      (out_ch.status),
    .out_last        (out_ch.last)
  );

endmodule

/* rtl/adsd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsd_checker
// Port-level checks on the decoded result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adsd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_first_byte,
  input  logic [7:0] out_second_byte,
  input  logic [1:0] out_byte_count,
  input  logic [1:0] out_status,
  input  logic       out_last
);

  // hold a stalled result word
  `ADSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_first_byte) && $stable(out_second_byte)
    && $stable(out_byte_count) && $stable(out_status) && $stable(out_last))

  // a word carrying decoded bytes always reports ok
  `ADSD_ASSERT_IMP(a_data_ok, out_valid && (out_byte_count != 2'd0),
    out_status == adsd_pkg::ST_OK)

  // end and error reports are single empty words
  `ADSD_ASSERT_IMP(a_status_empty, out_valid && (out_status != adsd_pkg::ST_OK),
    (out_byte_count == 2'd0) && out_last && (out_first_byte == 8'h00))

  // unused second byte reads as zero
  `ADSD_ASSERT_IMP(a_second_zero, out_valid && (out_byte_count != 2'd2),
    (out_second_byte == 8'h00) && (out_byte_count != 2'd3))

endmodule

bind adc_stream_decompressor adsd_checker u_adsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_first_byte  (out_ch.first_byte),
  .out_second_byte (out_ch.second_byte),
  .out_byte_count  (out_ch.byte_count),
  .out_status      (out_ch.status),
  .out_last        (out_ch.last)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_stream_decompressor testbench
// Feeds ADC phrases (literal runs, short and long copies, end commands) with
// random gaps and stalls, decodes the same words in a scoreboard and checks
// every result word field by field. The run closes with a copy that reaches
// past the filled history and then checks that the error holds.
// ----------------------------------------------------------------------------
typedef struct packed {
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic [1:0] status;
  logic       last;
} decoded_word_t;

class decoded_word_board;
  logic [7:0]                  hist [adsd_pkg::HIST_DEPTH];
  adsd_pkg::phase_t            phase;
  int                          run_left;
  logic [adsd_pkg::DIST_W-1:0] span;
  int                          wr_ptr;
  int                          fill;
  bit                          sticky_err;
  logic [7:0]                  fresh [$];
  decoded_word_t               pending_words [$];
  int                          failures;
  int                          checked;
  int                          decoded;

  function new();
    phase      = adsd_pkg::PH_OPCODE;
    run_left   = 0;
    span       = '0;
    wr_ptr     = 0;
    fill       = 0;
    sticky_err = 1'b0;
    failures   = 0;
    checked    = 0;
    decoded    = 0;
  endfunction

  function void queue_word(logic [7:0] b0, logic [7:0] b1, logic [1:0] cnt,
                           logic [1:0] st, logic fin);
    decoded_word_t w;
    w.first_byte  = b0;
    w.second_byte = b1;
    w.byte_count  = cnt;
    w.status      = st;
    w.last        = fin;
    pending_words.push_back(w);
  endfunction

  function void remember(logic [7:0] b);
    hist[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % adsd_pkg::HIST_DEPTH;
    if (fill < adsd_pkg::HIST_DEPTH) fill++;
    fresh.push_back(b);
    decoded++;
  endfunction

  // Copy run_left bytes from span back; returns 0 when span reaches too far.
  function bit replay(bit is_short);
    int d;
    int rd;
    d = int'(span);
    phase = adsd_pkg::PH_OPCODE;
    if (span > adsd_pkg::LONG_MAX_DIST || (is_short && span > adsd_pkg::SHORT_MAX_DIST) ||
        d > fill || d == 0) begin
      sticky_err = 1'b1;
      return 1'b0;
    end
    while (run_left > 0) begin
      rd = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + adsd_pkg::HIST_DEPTH - d;
      remember(hist[rd]);
      run_left--;
    end
    return 1'b1;
  endfunction

  function void absorb_word(logic cmd, logic [7:0] b);
    bit ok;
    int i;
    ok = 1'b1;
    fresh.delete();
    if (sticky_err) begin
      queue_word(8'h00, 8'h00, 2'd0, adsd_pkg::ST_ERR, 1'b1);
      return;
    end
    if (cmd == adsd_pkg::CMD_END) begin
      queue_word(8'h00, 8'h00, 2'd0,
                 (phase == adsd_pkg::PH_OPCODE) ? adsd_pkg::ST_END : adsd_pkg::ST_ERR, 1'b1);
      return;
    end
    case (phase)
      adsd_pkg::PH_LONG_HI: begin
        span  = {1'b0, b, 8'h00};
        phase = adsd_pkg::PH_LONG_LO;
      end
      adsd_pkg::PH_LONG_LO: begin
        span = span + adsd_pkg::DIST_W'(b) + 1'b1;
        ok   = replay(1'b0);
      end
      adsd_pkg::PH_SHORT: begin
        span = span + adsd_pkg::DIST_W'(b) + 1'b1;
        ok   = replay(1'b1);
      end
      adsd_pkg::PH_LITERAL: begin
        remember(b);
        if (run_left > 0) run_left--;
        if (run_left == 0) phase = adsd_pkg::PH_OPCODE;
      end
      default: begin
        if ((b & adsd_pkg::OP_LITERAL_BIT) != 0) begin
          phase    = adsd_pkg::PH_LITERAL;
          span     = '0;
          run_left = int'(b & adsd_pkg::LIT_LEN_MASK) + 1;
        end else if ((b & adsd_pkg::OP_LONG_BIT) != 0) begin
          phase    = adsd_pkg::PH_LONG_HI;
          span     = '0;
          run_left = int'(b & adsd_pkg::LONG_LEN_MASK) + 4;
        end else begin
          phase    = adsd_pkg::PH_SHORT;
          span     = adsd_pkg::DIST_W'({b[1:0], 8'h00});
          run_left = int'((b & adsd_pkg::SHORT_LEN_MASK) >> 2) + 3;
        end
      end
    endcase
    if (!ok) begin
      queue_word(8'h00, 8'h00, 2'd0, adsd_pkg::ST_ERR, 1'b1);
    end else if (fresh.size() == 0) begin
      queue_word(8'h00, 8'h00, 2'd0, adsd_pkg::ST_OK, 1'b1);
    end else begin
      for (i = 0; i < fresh.size(); i += 2) begin
        if (i + 1 < fresh.size())
          queue_word(fresh[i], fresh[i+1], 2'd2, adsd_pkg::ST_OK, (i + 2) >= fresh.size());
        else
          queue_word(fresh[i], 8'h00, 2'd1, adsd_pkg::ST_OK, 1'b1);
      end
    end
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  function void match_word(decoded_word_t got);
    decoded_word_t want;
    if (pending_words.size() == 0) begin
      $error("unexpected result word: byte_count %0d status %0d", got.byte_count,
             got.status);
      failures++;
      return;
    end
    want = pending_words.pop_front();
    checked++;
    check_field("first_byte", want.first_byte, got.first_byte);
    check_field("second_byte", want.second_byte, got.second_byte);
    check_field("byte_count", 8'(want.byte_count), 8'(got.byte_count));
    check_field("status", 8'(want.status), 8'(got.status));
    check_field("last", 8'(want.last), 8'(got.last));
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst_n;

  adsd_in_if  in_ch();
  adsd_out_if out_ch();

  adc_stream_decompressor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decoded_word_board board;
  int words_sent  = 0;
  int breaks_sent = 0;
  bit src_calm    = 1'b0;
  bit sink_calm   = 1'b0;
  int sink_hold   = 0;

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic cmd, logic [7:0] b);
    int gap;
    if ($urandom_range(39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.absorb_word(cmd, b);
    words_sent++;
  endtask

  // Drop an end command into a phrase now and then; it leaves the state alone.
  task automatic maybe_break();
    if ($urandom_range(15) == 0) begin
      send_word(adsd_pkg::CMD_END, 8'($urandom()));
      breaks_sent++;
    end
  endtask

  task automatic send_literal_run(int len);
    int i;
    send_word(adsd_pkg::CMD_DATA, adsd_pkg::OP_LITERAL_BIT | 8'(len - 1));
    for (i = 0; i < len; i++) begin
      maybe_break();
      send_word(adsd_pkg::CMD_DATA, 8'($urandom()));
    end
  endtask

  task automatic send_short_copy(int len, int reach);
    send_word(adsd_pkg::CMD_DATA, {2'b00, 4'(len - 3), 2'((reach - 1) >> 8)});
    maybe_break();
    send_word(adsd_pkg::CMD_DATA, 8'(reach - 1));
  endtask

  task automatic send_long_copy(int len, int reach);
    send_word(adsd_pkg::CMD_DATA, {2'b01, 6'(len - 4)});
    maybe_break();
    send_word(adsd_pkg::CMD_DATA, 8'((reach - 1) >> 8));
    maybe_break();
    send_word(adsd_pkg::CMD_DATA, 8'(reach - 1));
  endtask

  function automatic int pick_reach(int cap);
    int lim;
    int r;
    lim = (board.fill < cap) ? board.fill : cap;
    r = $urandom_range(9);
    if (r < 3) return $urandom_range(1, (lim < 8) ? lim : 8);
    if (r == 3) return lim;
    return $urandom_range(1, lim);
  endfunction

  // Result side: check accepted words, hold ready low for random stretches.
  initial begin : result_side
    decoded_word_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.first_byte  = out_ch.first_byte;
        got.second_byte = out_ch.second_byte;
        got.byte_count  = out_ch.byte_count;
        got.status      = out_ch.status;
        got.last        = out_ch.last;
        board.match_word(got);
      end
      if ($urandom_range(299) == 0) sink_calm = !sink_calm;
      if (sink_hold == 0 && !sink_calm && $urandom_range(7) == 0)
        sink_hold = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_ch.ready <= (sink_hold == 0);
      if (sink_hold > 0) sink_hold--;
    end
  end

  initial begin : run_limit
    #50_000_000;
    $display("adc_stream_decompressor regression: fail");
    $finish;
  end

  initial begin : stimulus
    int r;
    int len;
    board = new();
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= adsd_pkg::CMD_DATA;
    in_ch.in_byte <= 8'h00;
    out_ch.ready  <= 1'b0;
    rst_n         <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: clean end, shortest runs, shortest and longest copies, broken phrases.
    send_word(adsd_pkg::CMD_END, 8'hFF);
    send_word(adsd_pkg::CMD_DATA, 8'h80);
    send_word(adsd_pkg::CMD_DATA, 8'h00);
    send_word(adsd_pkg::CMD_DATA, 8'h81);
    send_word(adsd_pkg::CMD_DATA, 8'hFF);
    send_word(adsd_pkg::CMD_DATA, 8'hA5);
    send_word(adsd_pkg::CMD_DATA, 8'h00);  // short copy, 3 bytes back 1
    send_word(adsd_pkg::CMD_DATA, 8'h00);
    send_word(adsd_pkg::CMD_DATA, 8'h40);  // long copy, 4 bytes back 3, end inside
    send_word(adsd_pkg::CMD_END, 8'h00);
    send_word(adsd_pkg::CMD_DATA, 8'h00);
    send_word(adsd_pkg::CMD_DATA, 8'h02);
    send_word(adsd_pkg::CMD_DATA, 8'h7F);  // long copy, 67 bytes back 10
    send_word(adsd_pkg::CMD_DATA, 8'h00);
    send_word(adsd_pkg::CMD_DATA, 8'h09);
    send_word(adsd_pkg::CMD_DATA, 8'h3C);  // short copy, 18 bytes back 77
    send_word(adsd_pkg::CMD_DATA, 8'h4C);
    send_word(adsd_pkg::CMD_DATA, 8'h82);  // literal run with an end inside
    send_word(adsd_pkg::CMD_DATA, 8'h11);
    send_word(adsd_pkg::CMD_END, 8'h00);
    send_word(adsd_pkg::CMD_DATA, 8'h22);
    send_word(adsd_pkg::CMD_DATA, 8'h33);
    send_word(adsd_pkg::CMD_END, 8'h00);

    // Random phrases, led by one longest literal run.
    send_literal_run(128);
    while (words_sent < 470) begin
      r = $urandom_range(99);
      if (board.fill == 0 || r < 40) begin
        len = ($urandom_range(11) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
        send_literal_run(len);
      end else if (r < 65) begin
        send_short_copy($urandom_range(3, 18), pick_reach(1024));
      end else if (r < 92) begin
        if ($urandom_range(9) < 7) len = $urandom_range(4, 10);
        else len = ($urandom_range(9) == 0) ? 67 : $urandom_range(11, 67);
        send_long_copy(len, pick_reach(65536));
      end else begin
        send_word(adsd_pkg::CMD_END, 8'($urandom()));
      end
    end

    // Reach one byte past the filled history, then confirm the error holds.
    if (board.fill < 1024) send_short_copy(3, board.fill + 1);
    else send_long_copy(4, board.fill + 1);
    send_word(adsd_pkg::CMD_DATA, 8'h85);
    send_word(adsd_pkg::CMD_DATA, 8'h00);
    send_word(adsd_pkg::CMD_END, 8'h00);
    in_ch.valid <= 1'b0;

    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d input words (%0d end commands inside phrases); checked %0d result words",
             words_sent, breaks_sent, board.checked);
    $display("Decoded %0d bytes into a history of %0d, closing with a held distance error",
             board.decoded, board.fill);
    if (board.failures == 0) begin
      $display("adc_stream_decompressor regression: pass");
    end else begin
      $display("adc_stream_decompressor regression: fail");
    end
    $finish;
  end
endmodule
